@@ hw/rtl/three_floor_elevator_controller_defines.svh @@
// Assertion macros used by the elevator controller core (elv_core).
// ELV_ASSERT checks on every clock edge out of reset.
// ELV_ASSERT_ALWAYS checks on every clock edge, reset included.
`ifndef THREE_FLOOR_ELEVATOR_CONTROLLER_DEFINES_SVH
`define THREE_FLOOR_ELEVATOR_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
`define ELV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("elevator controller check failed");
`define ELV_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("elevator controller check failed");
`else
`define ELV_ASSERT(lbl, prop)
`define ELV_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ hw/rtl/elv_pkg.sv @@
package elv_pkg;

    // Width of the longest phase length (twelve times a 16-bit phase).
    localparam int PHASE_LEN_W = 20;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd5000;

    // Control modes
    localparam logic [3:0] M_NORMAL      = 4'd0;
    localparam logic [3:0] M_STOP_WAIT   = 4'd1;
    localparam logic [3:0] M_HOMING      = 4'd2;
    localparam logic [3:0] M_CRIT_OPEN   = 4'd3;
    localparam logic [3:0] M_CALL_WAIT   = 4'd4;
    localparam logic [3:0] M_RESET_CLOSE = 4'd5;
    localparam logic [3:0] M_OPEN        = 4'd6;
    localparam logic [3:0] M_DWELL       = 4'd7;
    localparam logic [3:0] M_CLOSE       = 4'd8;

    // Motor drive
    localparam logic [1:0] MOT_STOP = 2'd0;
    localparam logic [1:0] MOT_UP   = 2'd1;
    localparam logic [1:0] MOT_DOWN = 2'd2;

    // Floors
    localparam logic [1:0] FLOOR_1 = 2'd1;
    localparam logic [1:0] FLOOR_2 = 2'd2;
    localparam logic [1:0] FLOOR_3 = 2'd3;

    // Call latch bits
    localparam logic [3:0] CALL_F1     = 4'b0001;
    localparam logic [3:0] CALL_F2_UP  = 4'b0010;
    localparam logic [3:0] CALL_F2_DN  = 4'b0100;
    localparam logic [3:0] CALL_F3     = 4'b1000;
    localparam logic [3:0] CALL_F2_ALL = CALL_F2_UP | CALL_F2_DN;

    // Stop / reset latch bit positions
    localparam int SR_STOP  = 0;
    localparam int SR_RESET = 1;

    localparam logic [1:0] PHASE_LAST = 2'd3;
    localparam logic [3:0] LED_START  = 4'd14;
    localparam logic [3:0] LED_CLOSE0 = 4'd7;

    typedef struct packed {
        logic [3:0] calls;      // bit0 f1, bit1 f2 up, bit2 f2 down, bit3 f3
        logic       stop_btn;
        logic       reset_btn;
        logic [2:0] sensor_n;   // active low, bit0 floor 1
    } t_elv_item;

    typedef struct packed {
        logic       motor_up;
        logic       motor_down;
        logic [3:0] door_leds;
        logic [6:0] segments;
        logic [1:0] current_floor;
        logic       doors_closed;
    } t_elv_result;

    typedef struct packed {
        logic [3:0] calls;
        logic [1:0] sr;
        logic [2:0] sens;
        logic [1:0] last_floor;
        logic [1:0] motion;
        logic [1:0] saved_dir;
        logic       door_shut;
        logic [3:0] mode;
        logic [1:0] phase;
        logic [3:0] led;
        logic [3:0] served;
    } t_elv_state;

    localparam t_elv_state ELV_STATE_RESET = '{
        calls:       4'd0,
        sr:          2'd0,
        sens:        3'd0,
        last_floor:  FLOOR_1,
        motion:      MOT_STOP,
        saved_dir:   MOT_STOP,
        door_shut:   1'b1,
        mode:        M_NORMAL,
        phase:       2'd0,
        led:         LED_START,
        served:      4'd0
    };

    function automatic logic [3:0] f_open_led(input logic [1:0] phase);
        logic [3:0] led;
        case (phase)
            2'd0:    led = 4'd14;
            2'd1:    led = 4'd13;
            2'd2:    led = 4'd11;
            default: led = 4'd7;
        endcase
        return led;
    endfunction

    function automatic logic [3:0] f_close_led(input logic [1:0] phase);
        logic [3:0] led;
        case (phase)
            2'd0:    led = 4'd7;
            2'd1:    led = 4'd11;
            2'd2:    led = 4'd13;
            default: led = 4'd14;
        endcase
        return led;
    endfunction

    function automatic logic [6:0] f_segments(input logic [1:0] floor_num);
        logic [6:0] seg;
        case (floor_num)
            FLOOR_1: seg = 7'h7A;
            FLOOR_2: seg = 7'h24;
            FLOOR_3: seg = 7'h31;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

@@ hw/rtl/three_floor_elevator_controller.sv @@
// A request passes the input register and then the result register, which drives the output port.
// Throughput: one request per cycle while i_out_ready is high; input register and result register part the two sides.
// The door phase counter holds the sequencing, so each request is one short pass of logic.
// Reset (synchronous, active low): calls cleared, car at floor 1, doors closed,
// LEDs 14, phase length 5000 requests; no clearing pass, requests accepted at once.
module three_floor_elevator_controller import elv_pkg::*; #(
    parameter int COUNTER_WIDTH = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_call_floor1,
    input  logic        i_call_floor2_up,
    input  logic        i_call_floor2_down,
    input  logic        i_call_floor3,
    input  logic        i_stop_button,
    input  logic        i_reset_button,
    input  logic        i_floor1_sensor_n,
    input  logic        i_floor2_sensor_n,
    input  logic        i_floor3_sensor_n,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_motor_up,
    output logic        o_motor_down,
    output logic [3:0]  o_door_leds,
    output logic [6:0]  o_segments,
    output logic [1:0]  o_current_floor,
    output logic        o_doors_closed,
    // door phase length write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    t_elv_item   r_in;
    logic        r_out_valid;
    t_elv_result r_out;
    logic [15:0] r_phase_ticks;
    t_elv_result w_result;
    logic        w_step;

    // Advance the held request whenever the result register is free or draining.
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    // Configuration must only change while idle (the user's duty, not enforced here); every write is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_valid) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    // Input register: hold the sampled pin levels of one request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.calls     <= {i_call_floor3, i_call_floor2_down,
                               i_call_floor2_up, i_call_floor1};
            r_in.stop_btn  <= i_stop_button;
            r_in.reset_btn <= i_reset_button;
            r_in.sensor_n  <= {i_floor3_sensor_n, i_floor2_sensor_n, i_floor1_sensor_n};
        end
    end

    // Controller state and the one-pass update for a request.
    elv_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_item        (r_in),
        .i_phase_ticks (r_phase_ticks),
        .o_result      (w_result)
    );

    // Result register: load on advance, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_motor_up      = r_out.motor_up;
    assign o_motor_down    = r_out.motor_down;
    assign o_door_leds     = r_out.door_leds;
    assign o_segments      = r_out.segments;
    assign o_current_floor = r_out.current_floor;
    assign o_doors_closed  = r_out.doors_closed;

endmodule

@@ hw/rtl/elv_core.sv @@
`include "three_floor_elevator_controller_defines.svh"

module elv_core import elv_pkg::*; #(
    parameter int COUNTER_WIDTH = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  t_elv_item    i_item,
    input  logic [15:0]  i_phase_ticks,
    output t_elv_result  o_result
);

    localparam int LEN_W =
        ((COUNTER_WIDTH > PHASE_LEN_W) ? COUNTER_WIDTH : PHASE_LEN_W) + 1;

    t_elv_state               r_s, n_s;
    logic [COUNTER_WIDTH-1:0] r_tick, n_tick;

    logic [15:0]              w_base;
    logic [PHASE_LEN_W-1:0]   w_len_short, w_len_long;
    logic [LEN_W-1:0]         w_len, w_tick_inc;
    logic                     w_long, w_done, w_timed, w_settled;
    logic [COUNTER_WIDTH-1:0] w_tick_next;

    function automatic t_elv_state f_start_doors(input t_elv_state s,
                                                 input logic [3:0] mode);
        t_elv_state r;
        r             = s;
        r.motion      = MOT_STOP;
        r.door_shut   = 1'b0;
        r.led         = LED_START;
        r.phase       = 2'd0;
        r.mode        = mode;
        return r;
    endfunction

    function automatic t_elv_state f_serve(input t_elv_state s,
                                           input logic [3:0] mask);
        t_elv_state r;
        r        = s;
        r.served = mask;
        return f_start_doors(r, M_OPEN);
    endfunction

    function automatic t_elv_state f_sample_loc(input t_elv_state s,
                                                input logic [2:0] sensor_n);
        t_elv_state r;
        r = s;
        for (int i = 0; i < 3; i++) begin
            if (r.sens[i] != !sensor_n[i]) begin
                r.sens[i]    = !sensor_n[i];
                r.last_floor = 2'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic t_elv_state f_sample_all(input t_elv_state s,
                                                input t_elv_item item);
        t_elv_state r;
        r       = f_sample_loc(s, item.sensor_n);
        r.sr    = r.sr | {item.reset_btn, item.stop_btn};
        r.calls = r.calls | item.calls;
        return r;
    endfunction

    // Per-floor service rules; floor 2 skips a lone call against the car's motion.
    function automatic t_elv_state f_dispatch(input t_elv_state s);
        t_elv_state r;
        logic       f1, f2u, f2d, f3, dc;
        r   = s;
        f1  = |(s.calls & CALL_F1);
        f2u = |(s.calls & CALL_F2_UP);
        f2d = |(s.calls & CALL_F2_DN);
        f3  = |(s.calls & CALL_F3);
        dc  = s.door_shut;
        r.mode = M_NORMAL;
        case (s.last_floor)
            FLOOR_1: begin
                if (f1 && s.sens[0]) r = f_serve(r, CALL_F1);
                else if ((f2u || f2d || f3) && dc) r.motion = MOT_UP;
            end
            FLOOR_2: begin
                if (f2d && f2u && s.sens[1]) r = f_serve(r, CALL_F2_ALL);
                else if (f2d && s.sens[1] && s.motion != MOT_UP) r = f_serve(r, CALL_F2_DN);
                else if (f2u && s.sens[1] && s.motion != MOT_DOWN) r = f_serve(r, CALL_F2_UP);
                else if (f1 && dc) r.motion = MOT_DOWN;
                else if (f3 && dc) r.motion = MOT_UP;
            end
            FLOOR_3: begin
                if (f3 && s.sens[2]) r = f_serve(r, CALL_F3);
                else if ((f1 || f2u || f2d) && dc) r.motion = MOT_DOWN;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Phase timer: a zero length acts as one; a length past the counter range
    // ends when the counter is about to wrap.
    always_comb begin
        w_base      = (i_phase_ticks == 16'd0) ? 16'd1 : i_phase_ticks;
        w_len_short = PHASE_LEN_W'(w_base);
        w_len_long  = (w_len_short << 3) + (w_len_short << 2);
        w_long      = (r_s.mode == M_CRIT_OPEN) || (r_s.mode == M_DWELL);
        w_len       = LEN_W'(w_long ? w_len_long : w_len_short);
        w_tick_inc  = LEN_W'(r_tick) + LEN_W'(1);
        w_done      = (w_tick_inc >= w_len) || (&r_tick);
        w_tick_next = w_done ? '0 : r_tick + COUNTER_WIDTH'(1);
        w_timed     = r_s.mode inside {M_CRIT_OPEN, M_OPEN, M_DWELL, M_CLOSE, M_RESET_CLOSE};
        w_settled   = (r_s.mode == M_NORMAL) || (r_s.mode == M_STOP_WAIT);
    end

    always_comb begin
        t_elv_state s;
        s      = r_s;
        n_tick = '0;
        case (r_s.mode)
            M_STOP_WAIT: begin
                s.sr = s.sr | {i_item.reset_btn, i_item.stop_btn};
                if (s.sr[SR_STOP]) begin
                    s.sr[SR_STOP] = 1'b0;
                    if (s.saved_dir == MOT_UP || s.saved_dir == MOT_DOWN) begin
                        s.motion = s.saved_dir;
                    end
                    s.saved_dir = MOT_STOP;
                    s = f_dispatch(s);
                end
            end
            M_HOMING: begin
                s = f_sample_loc(s, i_item.sensor_n);
                if (s.sens[0]) s = f_start_doors(s, M_CRIT_OPEN);
            end
            M_CRIT_OPEN: begin
                n_tick = w_tick_next;
                if (w_done) begin
                    if (s.phase == PHASE_LAST) begin
                        s.phase = 2'd0;
                        s.mode  = M_CALL_WAIT;
                    end else begin
                        s.phase = s.phase + 2'd1;
                        s.led   = f_open_led(s.phase);
                    end
                end
            end
            M_CALL_WAIT: begin
                s = f_sample_all(s, i_item);
                if (s.calls != 4'd0) begin
                    s.led   = LED_CLOSE0;
                    s.phase = 2'd0;
                    s.mode  = M_RESET_CLOSE;
                end
            end
            M_OPEN: begin
                s        = f_sample_all(s, i_item);
                s.motion = MOT_STOP;
                n_tick   = w_tick_next;
                if (w_done) begin
                    if (s.phase == PHASE_LAST) begin
                        s.phase = 2'd0;
                        s.mode  = M_DWELL;
                    end else begin
                        s.phase = s.phase + 2'd1;
                        s.led   = f_open_led(s.phase);
                    end
                end
            end
            M_DWELL: begin
                n_tick = w_tick_next;
                if (w_done) begin
                    s.phase = 2'd0;
                    s.led   = LED_CLOSE0;
                    s.mode  = M_CLOSE;
                end
            end
            M_CLOSE, M_RESET_CLOSE: begin
                s        = f_sample_all(s, i_item);
                s.motion = MOT_STOP;
                n_tick   = w_tick_next;
                if (w_done) begin
                    if (s.phase == PHASE_LAST) begin
                        s.phase       = 2'd0;
                        s.door_shut   = 1'b1;
                        if (r_s.mode == M_CLOSE) begin
                            s.calls  = s.calls & ~s.served;
                            s.served = 4'd0;
                            s.mode   = M_NORMAL;
                        end else begin
                            s = f_dispatch(s);
                        end
                    end else begin
                        s.phase = s.phase + 2'd1;
                        s.led   = f_close_led(s.phase);
                    end
                end
            end
            default: begin
                // Stop beats reset, reset beats dispatch.
                s.mode = M_NORMAL;
                s      = f_sample_all(s, i_item);
                if (s.calls != 4'd0 || s.sr != 2'd0) begin
                    if (s.sr[SR_STOP]) begin
                        if (s.motion == MOT_UP || s.motion == MOT_DOWN) begin
                            s.saved_dir = s.motion;
                        end
                        s.motion      = MOT_STOP;
                        s.sr[SR_STOP] = 1'b0;
                        s.mode        = M_STOP_WAIT;
                    end else if (s.sr[SR_RESET]) begin
                        s.calls  = 4'd0;
                        s.sr     = 2'd0;
                        s.motion = MOT_STOP;
                        if (!s.sens[0]) begin
                            s.motion = MOT_DOWN;
                            s.mode   = M_HOMING;
                        end else begin
                            s = f_start_doors(s, M_CRIT_OPEN);
                        end
                    end else begin
                        s = f_dispatch(s);
                    end
                end
            end
        endcase
        n_s = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s    <= ELV_STATE_RESET;
            r_tick <= '0;
        end else if (i_step) begin
            r_s    <= n_s;
            r_tick <= n_tick;
        end
    end

    always_comb begin
        o_result.motor_up      = (n_s.motion == MOT_UP);
        o_result.motor_down    = (n_s.motion == MOT_DOWN);
        o_result.door_leds     = n_s.led;
        o_result.segments      = f_segments(n_s.last_floor);
        o_result.current_floor = n_s.last_floor;
        o_result.doors_closed  = n_s.door_shut;
    end

    `ELV_ASSERT(a_moving_doors_shut, r_s.motion != MOT_STOP |-> r_s.door_shut)
    `ELV_ASSERT(a_tick_idle_zero, !w_timed |-> r_tick == '0)
    `ELV_ASSERT(a_served_only_in_cycle, w_settled |-> r_s.served == 4'd0)
    `ELV_ASSERT(a_hold_without_step, !i_step |=> $stable(r_s) && $stable(r_tick))
    `ELV_ASSERT_ALWAYS(a_reset_state, !i_rst_n |=> r_s == ELV_STATE_RESET && r_tick == '0)

endmodule
